@@ hw/rtl/drts_pkg.sv @@
// shared types and constants for the dirty rectangle tracker
package drts_pkg;

    localparam int SUM_W   = 17;  // x + w without wrap
    localparam int COORD_W = 16;
    localparam int DIM_W   = 15;
    localparam int SCALE_W = 10;
    localparam int OUT_W   = 15;
    localparam int CFG_IDX_W = 3;
    localparam logic [SCALE_W-1:0] SCALE_UNITY = 10'd100;

    typedef enum logic [2:0] {
        OP_UNION        = 3'd0,
        OP_CURSOR_UNION = 3'd1,
        OP_OVERLAY_ON   = 3'd2,
        OP_OVERLAY_OFF  = 3'd3,
        OP_PRESENT      = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOGICAL_WIDTH  = 3'd0,
        REG_LOGICAL_HEIGHT = 3'd1,
        REG_PHYS_WIDTH     = 3'd2,
        REG_PHYS_HEIGHT    = 3'd3,
        REG_SCALE_PERCENT  = 3'd4,
        REG_FORCE_FRONT    = 3'd5,
        REG_PRESENT_ENABLE = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic in_ready;
        logic box_eval;
        logic mul_load;
        logic div_step;
        logic edge_store;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic present_taken;
        logic need_scale;
        logic last_box;
        logic div_done;
        logic last_edge;
        logic slots_empty;
    } sts_t;

endpackage

@@ hw/rtl/dirty_rect_tracker_scaler.sv @@
// top level of the dirty rectangle tracker with scaled present mapping
// union and overlay transfers stay idle; the next item is accepted the following cycle
// present: each box is evaluated, then stored if unscaled, else each edge is multiplied,
// divided by the one bit-per-cycle restoring divider (DW = bits of MAX_SCREEN_DIM, 15 at
// default) and stored; results then leave under back-pressure; one item in flight at a time
// async active-low reset clears dirty/overlay flags, control and config registers; scale goes to unity
module dirty_rect_tracker_scaler
#(
    parameter int MAX_SCREEN_DIM = 16384,
    parameter int EDGE_MARGIN    = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // rect_x[15:0], rect_y[31:16], rect_w[47:32], rect_h[63:48]
    input  logic [2:0]  s_tuser,   // op
    // copy rectangle stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // copy_left, copy_top, copy_right, copy_bottom (15 bits each), pad
    output logic [1:0]  m_tuser,   // from_cursor[0], needs_scaling[1]
    output logic        m_tlast    // last rectangle of the present
);

    drts_pkg::cmd_t cmd;
    drts_pkg::sts_t sts;

    // sequencer: decides when each box, edge and divider step happens
    drts_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // all arithmetic and all storage but the sequencer state live in the datapath
    drts_datapath
    #(
        .MAX_SCREEN_DIM (MAX_SCREEN_DIM),
        .EDGE_MARGIN    (EDGE_MARGIN)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

    // requests are taken only while the sequencer is idle
    assign s_tready = cmd.in_ready;

endmodule

@@ hw/rtl/drts_ctrl.sv @@
// controller state machine sequencing present processing
module drts_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  drts_pkg::sts_t  sts,
    output drts_pkg::cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_BOX   = 6'b000010,
        S_MUL   = 6'b000100,
        S_DIV   = 6'b001000,
        S_STORE = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.present_taken)
                begin
                    state_next = S_BOX;
                end
            end
            S_BOX:
            begin
                cmd.box_eval = 1'b1;
                if (sts.need_scale)
                begin
                    state_next = S_MUL;
                end
                else if (sts.last_box)
                begin
                    state_next = S_EMIT;
                end
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.edge_store = 1'b1;
                if (!sts.last_edge)
                begin
                    state_next = S_MUL;
                end
                else if (sts.last_box)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_BOX;
                end
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (sts.slots_empty)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/drts_datapath.sv @@
// boxes, configuration, edge mapper with serial divider and result slots
module drts_datapath
#(
    parameter int MAX_SCREEN_DIM = 16384,
    parameter int EDGE_MARGIN    = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [drts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [drts_pkg::DIM_W-1:0]       cfg_data,
    input  logic                             s_tvalid,
    input  logic [63:0]                      s_tdata,
    input  logic [2:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata,
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast,
    input  drts_pkg::cmd_t                   cmd,
    output drts_pkg::sts_t                   sts
);

    localparam int DW  = $clog2(MAX_SCREEN_DIM + 1);
    localparam int CNW = $clog2(DW);
    localparam int SW  = drts_pkg::SUM_W;

    // configuration
    logic [drts_pkg::DIM_W-1:0]   lw_reg, lh_reg, pw_reg, ph_reg;
    logic [drts_pkg::SCALE_W-1:0] scale_reg;
    logic                         ff_reg, pe_reg;

    // tracked state
    logic          content_dirty_reg, cursor_dirty_reg, overlay_reg;
    logic [DW-1:0] cbox_reg [4];
    logic [DW-1:0] kbox_reg [4];

    // present work state
    logic [1:0]    work_dirty_reg;
    logic          scaled_reg;
    logic          bidx_reg;
    logic [1:0]    eidx_reg;
    logic [DW-1:0] wedge_reg [4];
    logic [DW-1:0] slot_reg [2][4];
    logic [1:0]    slot_valid_reg;

    // divider
    logic [DW-1:0]  rem_reg, low_reg, quo_reg;
    logic [CNW-1:0] cnt_reg;

    // saturated dimensions
    function automatic logic [DW-1:0] sat_dim(input logic [drts_pkg::DIM_W-1:0] v);
        logic [SW-1:0] ve;
        ve = SW'(v);
        sat_dim = (ve > SW'(MAX_SCREEN_DIM)) ? DW'(MAX_SCREEN_DIM) : DW'(v);
    endfunction

    logic [DW-1:0] lw, lh, pw, ph;
    assign lw = sat_dim(lw_reg);
    assign lh = sat_dim(lh_reg);
    assign pw = sat_dim(pw_reg);
    assign ph = sat_dim(ph_reg);

    logic scaled;
    assign scaled = (scale_reg != drts_pkg::SCALE_UNITY) || (lw != pw) || (lh != ph);

    // input decode
    logic                          accept;
    drts_pkg::op_t                 op;
    logic [drts_pkg::COORD_W-1:0]  rx, ry, rw, rh;
    assign accept = s_tvalid && cmd.in_ready;
    assign op     = drts_pkg::op_t'(s_tuser);
    assign rx     = s_tdata[15:0];
    assign ry     = s_tdata[31:16];
    assign rw     = s_tdata[47:32];
    assign rh     = s_tdata[63:48];

    // union clip
    logic [SW-1:0] ux1, uy1, lwe, lhe;
    logic [DW-1:0] ux1c, uy1c;
    logic          u_ok, to_cursor;
    always_comb
    begin
        lwe  = SW'(lw);
        lhe  = SW'(lh);
        ux1  = SW'(rx) + SW'(rw);
        uy1  = SW'(ry) + SW'(rh);
        ux1c = (ux1 > lwe) ? lw : DW'(ux1);
        uy1c = (uy1 > lhe) ? lh : DW'(uy1);
        u_ok = !ff_reg && (rw != '0) && (rh != '0) && (lw != '0) && (lh != '0)
            && (SW'(rx) < lwe) && (SW'(ry) < lhe);
        to_cursor = (op == drts_pkg::OP_CURSOR_UNION) || overlay_reg;
    end

    // box evaluation for present
    logic [DW-1:0] b0, b1, b2, b3, x1c, y1c;
    logic          box_ok, need_scale;
    always_comb
    begin
        b0 = bidx_reg ? kbox_reg[0] : cbox_reg[0];
        b1 = bidx_reg ? kbox_reg[1] : cbox_reg[1];
        b2 = bidx_reg ? kbox_reg[2] : cbox_reg[2];
        b3 = bidx_reg ? kbox_reg[3] : cbox_reg[3];
        x1c = (b2 > lw) ? lw : b2;
        y1c = (b3 > lh) ? lh : b3;
        box_ok = work_dirty_reg[bidx_reg] && (b0 < lw) && (b1 < lh)
            && (b0 < x1c) && (b1 < y1c);
        need_scale = box_ok && scaled_reg && (pw != '0) && (ph != '0);
    end

    // edge mapping arithmetic
    logic [DW-1:0]   phys_sel, logi_sel, e_sel;
    logic [2*DW-1:0] prod, num;
    logic [DW:0]     trial, vm;
    logic            ge;
    logic [DW-1:0]   edge_val, y1_new;
    always_comb
    begin
        phys_sel = eidx_reg[0] ? ph : pw;
        logi_sel = eidx_reg[0] ? lh : lw;
        e_sel    = wedge_reg[eidx_reg];
        prod     = (2*DW)'(e_sel) * (2*DW)'(phys_sel);
        num      = prod + (eidx_reg[1] ? (2*DW)'(logi_sel - DW'(1)) : '0);
        trial    = {rem_reg, low_reg[DW-1]};
        ge       = trial >= {1'b0, logi_sel};
        vm       = {1'b0, quo_reg} + (DW+1)'(EDGE_MARGIN);
        if (!eidx_reg[1])
        begin
            edge_val = ({1'b0, quo_reg} >= (DW+1)'(EDGE_MARGIN))
                ? DW'({1'b0, quo_reg} - (DW+1)'(EDGE_MARGIN)) : '0;
        end
        else
        begin
            edge_val = (vm < {1'b0, phys_sel}) ? DW'(vm) : phys_sel;
        end
        y1_new = edge_val;
    end

    logic sel;
    assign sel = !slot_valid_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg            <= '0;
            lh_reg            <= '0;
            pw_reg            <= '0;
            ph_reg            <= '0;
            scale_reg         <= drts_pkg::SCALE_UNITY;
            ff_reg            <= 1'b0;
            pe_reg            <= 1'b0;
            content_dirty_reg <= 1'b0;
            cursor_dirty_reg  <= 1'b0;
            overlay_reg       <= 1'b0;
            work_dirty_reg    <= '0;
            scaled_reg        <= 1'b0;
            bidx_reg          <= 1'b0;
            eidx_reg          <= '0;
            slot_valid_reg    <= '0;
            cnt_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (drts_pkg::cfg_idx_t'(cfg_index))
                    drts_pkg::REG_LOGICAL_WIDTH:  lw_reg <= cfg_data;
                    drts_pkg::REG_LOGICAL_HEIGHT: lh_reg <= cfg_data;
                    drts_pkg::REG_PHYS_WIDTH:     pw_reg <= cfg_data;
                    drts_pkg::REG_PHYS_HEIGHT:    ph_reg <= cfg_data;
                    drts_pkg::REG_SCALE_PERCENT:  scale_reg <= cfg_data[drts_pkg::SCALE_W-1:0];
                    drts_pkg::REG_FORCE_FRONT:    ff_reg <= cfg_data[0];
                    drts_pkg::REG_PRESENT_ENABLE: pe_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            if (accept)
            begin
                unique case (op)
                    drts_pkg::OP_UNION, drts_pkg::OP_CURSOR_UNION:
                    begin
                        if (u_ok)
                        begin
                            if (to_cursor)
                            begin
                                cursor_dirty_reg <= 1'b1;
                                if (!cursor_dirty_reg || DW'(rx) < kbox_reg[0]) kbox_reg[0] <= DW'(rx);
                                if (!cursor_dirty_reg || DW'(ry) < kbox_reg[1]) kbox_reg[1] <= DW'(ry);
                                if (!cursor_dirty_reg || ux1c > kbox_reg[2]) kbox_reg[2] <= ux1c;
                                if (!cursor_dirty_reg || uy1c > kbox_reg[3]) kbox_reg[3] <= uy1c;
                            end
                            else
                            begin
                                content_dirty_reg <= 1'b1;
                                if (!content_dirty_reg || DW'(rx) < cbox_reg[0]) cbox_reg[0] <= DW'(rx);
                                if (!content_dirty_reg || DW'(ry) < cbox_reg[1]) cbox_reg[1] <= DW'(ry);
                                if (!content_dirty_reg || ux1c > cbox_reg[2]) cbox_reg[2] <= ux1c;
                                if (!content_dirty_reg || uy1c > cbox_reg[3]) cbox_reg[3] <= uy1c;
                            end
                        end
                    end
                    drts_pkg::OP_OVERLAY_ON:  overlay_reg <= 1'b1;
                    drts_pkg::OP_OVERLAY_OFF: overlay_reg <= 1'b0;
                    drts_pkg::OP_PRESENT:
                    begin
                        work_dirty_reg    <= pe_reg ? {cursor_dirty_reg, content_dirty_reg} : 2'b00;
                        content_dirty_reg <= 1'b0;
                        cursor_dirty_reg  <= 1'b0;
                        scaled_reg        <= scaled;
                        bidx_reg          <= 1'b0;
                        slot_valid_reg    <= '0;
                    end
                    default: ;
                endcase
            end

            if (cmd.box_eval)
            begin
                wedge_reg[0] <= b0;
                wedge_reg[1] <= b1;
                wedge_reg[2] <= x1c;
                wedge_reg[3] <= y1c;
                eidx_reg     <= '0;
                if (!need_scale)
                begin
                    slot_reg[bidx_reg][0]    <= b0;
                    slot_reg[bidx_reg][1]    <= b1;
                    slot_reg[bidx_reg][2]    <= x1c;
                    slot_reg[bidx_reg][3]    <= y1c;
                    slot_valid_reg[bidx_reg] <= box_ok && !scaled_reg;
                    bidx_reg                 <= 1'b1;
                end
            end

            if (cmd.mul_load)
            begin
                rem_reg <= num[2*DW-1:DW];
                low_reg <= num[DW-1:0];
                cnt_reg <= '0;
            end

            if (cmd.div_step)
            begin
                rem_reg <= ge ? DW'(trial - {1'b0, logi_sel}) : DW'(trial);
                low_reg <= {low_reg[DW-2:0], 1'b0};
                quo_reg <= {quo_reg[DW-2:0], ge};
                cnt_reg <= cnt_reg + CNW'(1);
            end

            if (cmd.edge_store)
            begin
                slot_reg[bidx_reg][eidx_reg] <= edge_val;
                if (eidx_reg == 2'd3)
                begin
                    slot_valid_reg[bidx_reg] <= (slot_reg[bidx_reg][0] < slot_reg[bidx_reg][2])
                        && (slot_reg[bidx_reg][1] < y1_new);
                    bidx_reg <= 1'b1;
                end
                else
                begin
                    eidx_reg <= eidx_reg + 2'd1;
                end
            end

            if (m_tvalid && m_tready)
            begin
                slot_valid_reg[sel] <= 1'b0;
            end
        end
    end

    // result channel
    assign m_tvalid = cmd.emit && (slot_valid_reg != 2'b00);
    assign m_tlast  = !(slot_valid_reg[0] && slot_valid_reg[1]);
    assign m_tdata  = {4'b0000,
                       drts_pkg::OUT_W'(slot_reg[sel][3]),
                       drts_pkg::OUT_W'(slot_reg[sel][2]),
                       drts_pkg::OUT_W'(slot_reg[sel][1]),
                       drts_pkg::OUT_W'(slot_reg[sel][0])};
    assign m_tuser  = {scaled_reg, sel};

    always_comb
    begin
        sts.present_taken = accept && (op == drts_pkg::OP_PRESENT);
        sts.need_scale    = need_scale;
        sts.last_box      = bidx_reg;
        sts.div_done      = (cnt_reg == CNW'(DW - 1));
        sts.last_edge     = (eidx_reg == 2'd3);
        sts.slots_empty   = (slot_valid_reg == 2'b00);
    end

endmodule

@@ dv/dirty_rect_tracker_scaler_tb.sv @@
// self-checking testbench for the dirty rectangle tracker with scaled present mapping
module dirty_rect_tracker_scaler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM = 16384;
    localparam int MARGIN  = 8;
    localparam int LIMIT_CYCLES = 2000000;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
    } req_t;

    typedef struct packed {
        logic [14:0] left;
        logic [14:0] top;
        logic [14:0] right;
        logic [14:0] bottom;
        logic        cursor;
        logic        scaled;
        logic        last;
    } copy_t;

    typedef struct {
        int unsigned x0, y0, x1, y1;
    } box_s;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [14:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    dirty_rect_tracker_scaler dut (.*);

    always #4 clk = ~clk;

    // predictor state
    int unsigned lw_reg, lh_reg, pw_reg, ph_reg, scale_reg, front_reg, enable_reg;
    bit content_dirty_m, cursor_dirty_m, overlay_m;
    box_s content_box_m, cursor_box_m;

    req_t  pending_reqs[$];
    copy_t expected_copies[$];
    int    errors = 0;
    int    cycles = 0;
    bit    quiet = 1'b0;     // no idling near the end
    int    s_gap = 0;
    int    m_gap = 0;

    function automatic int unsigned sat(int unsigned v);
        return v > MAX_DIM ? MAX_DIM : v;
    endfunction

    function automatic void merge_rect(ref bit dirty, ref box_s b, input req_t r);
        int unsigned lw, lh, x1, y1;
        lw = sat(lw_reg);
        lh = sat(lh_reg);
        if (front_reg != 0 || r.w == 0 || r.h == 0 || lw == 0 || lh == 0) return;
        if (r.x >= lw || r.y >= lh) return;
        x1 = r.x + r.w;
        y1 = r.y + r.h;
        if (x1 > lw) x1 = lw;
        if (y1 > lh) y1 = lh;
        if (r.x >= x1 || r.y >= y1) return;
        if (!dirty) begin
            b.x0 = r.x; b.y0 = r.y; b.x1 = x1; b.y1 = y1;
            dirty = 1'b1;
            return;
        end
        if (r.x < b.x0) b.x0 = r.x;
        if (r.y < b.y0) b.y0 = r.y;
        if (x1 > b.x1) b.x1 = x1;
        if (y1 > b.y1) b.y1 = y1;
    endfunction

    function automatic int unsigned floor_edge(int unsigned e, int unsigned p, int unsigned l);
        longint unsigned v;
        v = (longint'(e) * p) / l;
        return v >= MARGIN ? v - MARGIN : 0;
    endfunction

    function automatic int unsigned ceil_edge(int unsigned e, int unsigned p, int unsigned l);
        longint unsigned v;
        v = (longint'(e) * p + l - 1) / l;
        return (v + MARGIN < p) ? v + MARGIN : p;
    endfunction

    // maps one box to copy edges; returns 0 when the box yields nothing
    function automatic bit map_rect(input box_s b, input bit scaled, output box_s r);
        int unsigned lw, lh, pw, ph, x1, y1;
        lw = sat(lw_reg); lh = sat(lh_reg); pw = sat(pw_reg); ph = sat(ph_reg);
        r = '{0, 0, 0, 0};
        if (b.x0 >= lw || b.y0 >= lh) return 0;
        x1 = b.x1 > lw ? lw : b.x1;
        y1 = b.y1 > lh ? lh : b.y1;
        if (b.x0 >= x1 || b.y0 >= y1) return 0;
        if (!scaled) begin
            r = '{b.x0, b.y0, x1, y1};
            return 1;
        end
        if (pw == 0 || ph == 0) return 0;
        r.x0 = floor_edge(b.x0, pw, lw);
        r.y0 = floor_edge(b.y0, ph, lh);
        r.x1 = ceil_edge(x1, pw, lw);
        r.y1 = ceil_edge(y1, ph, lh);
        return r.x0 < r.x1 && r.y0 < r.y1;
    endfunction

    function automatic void predict_request(req_t r);
        bit scaled;
        box_s m;
        int first_idx;
        first_idx = expected_copies.size();
        case (r.op)
            drts_pkg::OP_UNION:
                if (overlay_m) merge_rect(cursor_dirty_m, cursor_box_m, r);
                else merge_rect(content_dirty_m, content_box_m, r);
            drts_pkg::OP_CURSOR_UNION: merge_rect(cursor_dirty_m, cursor_box_m, r);
            drts_pkg::OP_OVERLAY_ON:   overlay_m = 1'b1;
            drts_pkg::OP_OVERLAY_OFF:  overlay_m = 1'b0;
            drts_pkg::OP_PRESENT:
            begin
                if (enable_reg == 0) begin
                    content_dirty_m = 1'b0;
                    cursor_dirty_m = 1'b0;
                end
                else begin
                    scaled = scale_reg != 100 || sat(lw_reg) != sat(pw_reg) ||
                             sat(lh_reg) != sat(ph_reg);
                    if (content_dirty_m) begin
                        content_dirty_m = 1'b0;
                        if (map_rect(content_box_m, scaled, m))
                            expected_copies.push_back({m.x0[14:0], m.y0[14:0], m.x1[14:0],
                                                       m.y1[14:0], 1'b0, scaled, 1'b0});
                    end
                    if (cursor_dirty_m) begin
                        cursor_dirty_m = 1'b0;
                        if (map_rect(cursor_box_m, scaled, m))
                            expected_copies.push_back({m.x0[14:0], m.y0[14:0], m.x1[14:0],
                                                       m.y1[14:0], 1'b1, scaled, 1'b0});
                    end
                    if (expected_copies.size() > first_idx)
                        expected_copies[expected_copies.size()-1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // driver: present one request at a time, random bursts of idling
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n) begin
            if (s_tvalid && s_tready) predict_request(req_t'({s_tuser, s_tdata[15:0],
                s_tdata[31:16], s_tdata[47:32], s_tdata[63:48]}));
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0) begin
                    req_t r;
                    r = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= r.op;
                    s_tdata <= {r.h, r.w, r.y, r.x};
                    if (!quiet && $urandom_range(0, 5) == 0) s_gap <= $urandom_range(1, 12);
                end
                else s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check each copy rectangle transfer, random back-pressure
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                copy_t got, exp_c;
                got = {m_tdata[14:0], m_tdata[29:15], m_tdata[44:30], m_tdata[59:45],
                       m_tuser[0], m_tuser[1], m_tlast};
                if (expected_copies.size() == 0) begin
                    $display("%0t: unexpected copy transfer, expected none, actual %h", $realtime,
                             got);
                    errors++;
                end
                else begin
                    exp_c = expected_copies.pop_front();
                    if (got.left != exp_c.left)
                        $display("%0t: copy_left expected %0d actual %0d", $realtime, exp_c.left,
                                 got.left);
                    if (got.top != exp_c.top)
                        $display("%0t: copy_top expected %0d actual %0d", $realtime, exp_c.top,
                                 got.top);
                    if (got.right != exp_c.right)
                        $display("%0t: copy_right expected %0d actual %0d", $realtime,
                                 exp_c.right, got.right);
                    if (got.bottom != exp_c.bottom)
                        $display("%0t: copy_bottom expected %0d actual %0d", $realtime,
                                 exp_c.bottom, got.bottom);
                    if (got.cursor != exp_c.cursor)
                        $display("%0t: from_cursor expected %0d actual %0d", $realtime,
                                 exp_c.cursor, got.cursor);
                    if (got.scaled != exp_c.scaled)
                        $display("%0t: needs_scaling expected %0d actual %0d", $realtime,
                                 exp_c.scaled, got.scaled);
                    if (got.last != exp_c.last)
                        $display("%0t: last expected %0d actual %0d", $realtime, exp_c.last,
                                 got.last);
                    if (got != exp_c) errors++;
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0) m_gap <= $urandom_range(1, 12);
            end
        end
    end

    // timeout guard
    always @(posedge clk) begin
        if (cycles >= LIMIT_CYCLES) begin
            $display("dirty_rect_tracker_scaler_tb: done, errors");
            $finish;
        end
    end

    task automatic write_reg(drts_pkg::cfg_idx_t idx, int unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[14:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            drts_pkg::REG_LOGICAL_WIDTH:  lw_reg = val & 16'h7fff;
            drts_pkg::REG_LOGICAL_HEIGHT: lh_reg = val & 16'h7fff;
            drts_pkg::REG_PHYS_WIDTH:     pw_reg = val & 16'h7fff;
            drts_pkg::REG_PHYS_HEIGHT:    ph_reg = val & 16'h7fff;
            drts_pkg::REG_SCALE_PERCENT:  scale_reg = val & 10'h3ff;
            drts_pkg::REG_FORCE_FRONT:    front_reg = val & 1;
            drts_pkg::REG_PRESENT_ENABLE: enable_reg = val & 1;
            default: ;
        endcase
    endtask

    // wait until every request is sent and every copy has arrived, then let the block settle
    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_copies.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_screen(int unsigned lw, int unsigned lh, int unsigned pw,
                              int unsigned ph, int unsigned sc, int unsigned ff,
                              int unsigned en);
        drain();
        write_reg(drts_pkg::REG_LOGICAL_WIDTH, lw);
        write_reg(drts_pkg::REG_LOGICAL_HEIGHT, lh);
        write_reg(drts_pkg::REG_PHYS_WIDTH, pw);
        write_reg(drts_pkg::REG_PHYS_HEIGHT, ph);
        write_reg(drts_pkg::REG_SCALE_PERCENT, sc);
        write_reg(drts_pkg::REG_FORCE_FRONT, ff);
        write_reg(drts_pkg::REG_PRESENT_ENABLE, en);
    endtask

    function automatic void queue_req(drts_pkg::op_t op, int unsigned x, int unsigned y,
                                      int unsigned w, int unsigned h);
        pending_reqs.push_back({op, x[15:0], y[15:0], w[15:0], h[15:0]});
    endfunction

    // random coordinate mostly near or inside the screen, sometimes any 16-bit value
    function automatic int unsigned rand_coord(int unsigned dim);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
        return $urandom_range(0, dim + 16);
    endfunction

    function automatic void queue_random(int n, int unsigned lw, int unsigned lh);
        drts_pkg::op_t op;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4, 5: op = drts_pkg::OP_UNION;
                6, 7, 8:          op = drts_pkg::OP_CURSOR_UNION;
                9:                op = drts_pkg::OP_OVERLAY_ON;
                10:               op = drts_pkg::OP_OVERLAY_OFF;
                11, 12, 13:       op = drts_pkg::OP_PRESENT;
                default:          op = drts_pkg::op_t'($urandom_range(0, 7));
            endcase
            if ($urandom_range(0, 19) == 0)
                queue_req(op, $urandom, $urandom, $urandom, $urandom);
            else
                queue_req(op, rand_coord(lw), rand_coord(lh), $urandom_range(0, lw / 2 + 8),
                          $urandom_range(0, lh / 2 + 8));
        end
    endfunction

    initial begin
        int unsigned lw, lh, pw, ph;
        lw_reg = 0; lh_reg = 0; pw_reg = 0; ph_reg = 0;
        scale_reg = 100; front_reg = 0; enable_reg = 0;
        content_dirty_m = 0; cursor_dirty_m = 0; overlay_m = 0;
        content_box_m = '{0, 0, 0, 0};
        cursor_box_m = '{0, 0, 0, 0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: unscaled 640x480
        set_screen(640, 480, 640, 480, 100, 0, 1);
        queue_req(drts_pkg::OP_UNION, 0, 0, 65535, 65535);
        queue_req(drts_pkg::OP_CURSOR_UNION, 10, 20, 5, 5);
        queue_req(drts_pkg::OP_PRESENT, 0, 0, 0, 0);
        queue_req(drts_pkg::OP_UNION, 5, 5, 0, 10);          // zero width ignored
        queue_req(drts_pkg::OP_UNION, 640, 5, 10, 10);       // off screen ignored
        queue_req(drts_pkg::OP_PRESENT, 0, 0, 0, 0);         // nothing dirty
        queue_req(drts_pkg::OP_OVERLAY_ON, 0, 0, 0, 0);
        queue_req(drts_pkg::OP_UNION, 100, 100, 10, 10);     // lands in cursor box
        queue_req(drts_pkg::OP_OVERLAY_OFF, 0, 0, 0, 0);
        queue_req(drts_pkg::OP_UNION, 65535, 65535, 65535, 65535);
        queue_req(drts_pkg::op_t'(3'd7), 1, 1, 1, 1);
        queue_req(drts_pkg::OP_UNION, 1, 2, 3, 4);
        queue_req(drts_pkg::OP_PRESENT, 0, 0, 0, 0);
        // screen shrinks between union and present: box clipped or skipped
        queue_req(drts_pkg::OP_UNION, 600, 400, 30, 30);
        queue_req(drts_pkg::OP_CURSOR_UNION, 100, 100, 30, 30);
        set_screen(320, 240, 320, 240, 100, 0, 1);
        queue_req(drts_pkg::OP_PRESENT, 0, 0, 0, 0);
        // scaled with margin clamping
        set_screen(320, 240, 1000, 750, 150, 0, 1);
        queue_req(drts_pkg::OP_UNION, 0, 0, 320, 240);
        queue_req(drts_pkg::OP_CURSOR_UNION, 317, 1, 3, 7);
        queue_req(drts_pkg::OP_PRESENT, 0, 0, 0, 0);
        // force front, then disabled present clears boxes
        set_screen(320, 240, 320, 240, 100, 1, 1);
        queue_req(drts_pkg::OP_UNION, 1, 1, 5, 5);
        queue_req(drts_pkg::OP_PRESENT, 0, 0, 0, 0);
        set_screen(320, 240, 320, 240, 100, 0, 0);
        queue_req(drts_pkg::OP_UNION, 1, 1, 5, 5);
        queue_req(drts_pkg::OP_PRESENT, 0, 0, 0, 0);
        set_screen(320, 240, 0, 240, 100, 0, 1);   // scaled with zero physical width
        queue_req(drts_pkg::OP_UNION, 1, 1, 5, 5);
        queue_req(drts_pkg::OP_PRESENT, 0, 0, 0, 0);
        set_screen(0, 0, 100, 100, 100, 0, 1);     // zero logical size
        queue_req(drts_pkg::OP_UNION, 0, 0, 5, 5);
        queue_req(drts_pkg::OP_PRESENT, 0, 0, 0, 0);
        set_screen(32767, 32767, 32767, 32767, 1023, 0, 1); // saturated dimensions
        queue_req(drts_pkg::OP_UNION, 0, 0, 65535, 65535);
        queue_req(drts_pkg::OP_CURSOR_UNION, 16383, 16383, 1, 1);
        queue_req(drts_pkg::OP_PRESENT, 0, 0, 0, 0);

        // random phases across several settings
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: begin lw = 64; lh = 48; pw = 64; ph = 48; end
                1: begin lw = 16384; lh = 16384; pw = 16384; ph = 16384; end
                2: begin lw = 1; lh = 1; pw = 16384; ph = 16384; end
                3: begin lw = 16384; lh = 9000; pw = 3; ph = 2; end
                default:
                begin
                    lw = $urandom_range(1, 2000); lh = $urandom_range(1, 2000);
                    pw = $urandom_range(0, 1) ? lw : $urandom_range(1, 4000);
                    ph = $urandom_range(0, 1) ? lh : $urandom_range(1, 4000);
                end
            endcase
            set_screen(lw, lh, pw, ph, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023) : 100,
                       ($urandom_range(0, 9) == 0), ($urandom_range(0, 7) != 0));
            if (phase == 9) quiet = 1'b1;
            queue_random(200, lw, lh);
        end

        drain();
        if (errors == 0)
            $display("dirty_rect_tracker_scaler_tb: done, clean");
        else
            $display("dirty_rect_tracker_scaler_tb: done, errors");
        $finish;
    end

endmodule
